@@ rtl/vna_pkg.sv @@
// Shared types, constants and helpers for the vertex normal accumulator.
// No dependencies; every other file of the block imports this package.
package vna_pkg;

  localparam int unsigned VERTICES = 1024;
  localparam int unsigned ADDR_W   = $clog2(VERTICES);
  localparam int unsigned CMP_W    = 17;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned CROSS_W  = PROD_W + 1;
  localparam int unsigned HALF_W   = SUM_W / 2;
  localparam int unsigned SQP_W    = 2 * HALF_W;
  localparam int unsigned ROOT_W   = 49;
  localparam int unsigned SQ_W     = 2 * ROOT_W;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned QUOT_W   = 15;
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned NORM_W   = 16;
  localparam int unsigned CNT_W    = 6;

  localparam int unsigned SQ_HI_SH  = 2 * HALF_W;
  localparam int unsigned SQ_MID_SH = HALF_W + 1;

  localparam logic [CNT_W-1:0] LAST_CORNER = CNT_W'(2);
  localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(6);
  localparam logic [CNT_W-1:0] SQ_LAST     = CNT_W'(9);
  localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(QUOT_W - 1);

  localparam logic [QUOT_W-1:0] ONE_Q14 = QUOT_W'(16384);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          read_index;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic                      zero_length;
  } result_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_CAPTURE,
    CMD_LOAD,
    CMD_POS_RD,
    CMD_POS_LAT,
    CMD_DIFF,
    CMD_MUL,
    CMD_SUM_RD,
    CMD_SUM_WR,
    CMD_NRM_RD,
    CMD_NRM_LAT,
    CMD_SQ,
    CMD_SQRT,
    CMD_DIV_INIT,
    CMD_DIV,
    CMD_DIV_END,
    CMD_ZERO,
    CMD_PUSH
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [1:0]       sel;
    logic [CNT_W-1:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       vtx_ok;
    logic       tri_ok;
    logic       sum_zero;
    logic       out_full;
  } dp_status_t;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return CMP_W'(idx) < CMP_W'(VERTICES);
  endfunction

endpackage

@@ rtl/vna_if.sv @@
// Valid/ready stream interfaces for the input items and the results.
// Depends on vna_pkg for field widths.
interface vna_in_if;
  import vna_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [IDX_W-1:0]          vertex_index;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [IDX_W-1:0]          corner_a;
  logic [IDX_W-1:0]          corner_b;
  logic [IDX_W-1:0]          corner_c;
  modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
  import vna_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         read_index;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;
  logic                     zero_length;
  modport source (output valid, read_index, normal_x, normal_y, normal_z, zero_length,
                  input ready);
  modport sink   (input valid, read_index, normal_x, normal_y, normal_z, zero_length,
                  output ready);
endinterface

@@ rtl/vna_ctrl.sv @@
// Sequencer for the vertex normal accumulator: steps the datapath per transaction.
// Depends on vna_pkg (command and status types).
module vna_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  vna_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output vna_pkg::ctrl_cmd_t  cmd_o
);
  import vna_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LOAD, S_PRD, S_PLAT, S_DIFF, S_MUL, S_SRD, S_SWR,
    S_NRD, S_NLAT, S_SQ, S_SQRT, S_DINIT, S_DIV, S_DEND, S_ZERO, S_PUSH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             ready_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    comp_d    = comp_q;
    cmd_o.cmd  = CMD_IDLE;
    cmd_o.sel  = cnt_q[1:0];
    cmd_o.step = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.cmd = CMD_CAPTURE;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_d  = '0;
        comp_d = '0;
        case (status_i.op)
          OP_LOAD: state_d = status_i.vtx_ok ? S_LOAD : S_IDLE;
          OP_TRI:  state_d = status_i.tri_ok ? S_PRD : S_IDLE;
          OP_READ: state_d = status_i.vtx_ok ? S_NRD : S_ZERO;
          default: state_d = S_IDLE;
        endcase
      end
      S_LOAD: begin
        cmd_o.cmd = CMD_LOAD;
        state_d   = S_IDLE;
      end
      S_PRD: begin
        cmd_o.cmd = CMD_POS_RD;
        state_d   = S_PLAT;
      end
      S_PLAT: begin
        cmd_o.cmd = CMD_POS_LAT;
        if (cnt_q == LAST_CORNER) begin
          cnt_d   = '0;
          state_d = S_DIFF;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_PRD;
        end
      end
      S_DIFF: begin
        cmd_o.cmd = CMD_DIFF;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.cmd = CMD_MUL;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_SRD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SRD: begin
        cmd_o.cmd = CMD_SUM_RD;
        state_d   = S_SWR;
      end
      S_SWR: begin
        cmd_o.cmd = CMD_SUM_WR;
        if (cnt_q == LAST_CORNER) begin
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_NRD: begin
        cmd_o.cmd = CMD_NRM_RD;
        state_d   = S_NLAT;
      end
      S_NLAT: begin
        cmd_o.cmd = CMD_NRM_LAT;
        cnt_d     = '0;
        state_d   = status_i.sum_zero ? S_ZERO : S_SQ;
      end
      S_SQ: begin
        cmd_o.cmd = CMD_SQ;
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.cmd = CMD_SQRT;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          comp_d  = '0;
          state_d = S_DINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DINIT: begin
        cmd_o.cmd = CMD_DIV_INIT;
        cmd_o.sel = comp_q;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.cmd = CMD_DIV;
        cmd_o.sel = comp_q;
        if (cnt_q == DIV_LAST) begin
          state_d = S_DEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DEND: begin
        cmd_o.cmd = CMD_DIV_END;
        cmd_o.sel = comp_q;
        if (comp_q == 2'd2) begin
          state_d = S_PUSH;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_DINIT;
        end
      end
      S_ZERO: begin
        cmd_o.cmd = CMD_ZERO;
        state_d   = S_PUSH;
      end
      S_PUSH: begin
        if (!status_i.out_full) begin
          cmd_o.cmd = CMD_PUSH;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

@@ rtl/vna_datapath.sv @@
// Datapath: position and sum memories, cross product, saturating accumulate,
// squared length, bitwise square root and quotient. Depends on vna_pkg.
module vna_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vna_pkg::ctrl_cmd_t  cmd_i,
  input  vna_pkg::item_t      item_i,
  input  logic                out_ready_i,
  output vna_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  output vna_pkg::result_t    result_o
);
  import vna_pkg::*;

  item_t                      item_q;
  result_t                    res_q, out_q;
  logic                       out_valid_q;

  logic [3*COORD_W-1:0]       pos_mem [VERTICES];
  logic [3*SUM_W-1:0]         sum_mem [VERTICES];
  logic [3*COORD_W-1:0]       pos_rd_q;
  logic [3*SUM_W-1:0]         sum_rd_q;

  logic signed [COORD_W-1:0]  vx_q [3];
  logic signed [COORD_W-1:0]  vy_q [3];
  logic signed [COORD_W-1:0]  vz_q [3];
  logic signed [DIFF_W-1:0]   ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [2:0]                 pidx_q;
  logic signed [CROSS_W-1:0]  nx_q, ny_q, nz_q;

  logic [SUM_W-1:0]           mag_q [3];
  logic [2:0]                 neg_q;
  logic [SQP_W-1:0]           sqp_q;
  logic [1:0]                 spart_q;
  logic [SQ_W-1:0]            acc_q;
  logic [ROOT_W-1:0]          root_q;
  logic [REM_W-1:0]           rem_q;
  logic [QUOT_W-1:0]          dsh_q, quo_q;

  logic [ADDR_W-1:0]          vtx_addr, corner_addr, sum_addr;
  logic                       pos_we, sum_we, sum_re, pos_re;
  logic [3*SUM_W-1:0]         sum_wdata;
  logic signed [DIFF_W-1:0]   mul_a, mul_b;
  logic [1:0]                 sq_comp, sq_part;
  logic [HALF_W-1:0]          sq_a, sq_b;
  logic [SUM_W-1:0]           sq_mag;
  logic [REM_W-1:0]           rt_rem, rt_trial, dv_rem, dv_div;
  logic                       rt_ge, dv_ge;
  logic [QUOT_W-1:0]          q_clamp;
  logic [NORM_W-1:0]          q_signed;

  function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                               input logic signed [CROSS_W-1:0] n);
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    vtx_addr = ADDR_W'(item_q.vertex_index);
    case (cmd_i.sel)
      2'd0:    corner_addr = ADDR_W'(item_q.corner_a);
      2'd1:    corner_addr = ADDR_W'(item_q.corner_b);
      default: corner_addr = ADDR_W'(item_q.corner_c);
    endcase
    sum_addr  = (cmd_i.cmd == CMD_NRM_RD || cmd_i.cmd == CMD_LOAD) ? vtx_addr : corner_addr;
    pos_we    = (cmd_i.cmd == CMD_LOAD);
    pos_re    = (cmd_i.cmd == CMD_POS_RD);
    sum_re    = (cmd_i.cmd == CMD_SUM_RD) || (cmd_i.cmd == CMD_NRM_RD);
    sum_we    = (cmd_i.cmd == CMD_LOAD) || (cmd_i.cmd == CMD_SUM_WR);
    if (cmd_i.cmd == CMD_LOAD) begin
      sum_wdata = '0;
    end else begin
      sum_wdata = {sat_add(sum_rd_q[3*SUM_W-1:2*SUM_W], nx_q),
                   sat_add(sum_rd_q[2*SUM_W-1:SUM_W], ny_q),
                   sat_add(sum_rd_q[SUM_W-1:0], nz_q)};
    end

    case (cmd_i.step[2:0])
      3'd0:    begin mul_a = uy_q; mul_b = wz_q; end
      3'd1:    begin mul_a = uz_q; mul_b = wy_q; end
      3'd2:    begin mul_a = uz_q; mul_b = wx_q; end
      3'd3:    begin mul_a = ux_q; mul_b = wz_q; end
      3'd4:    begin mul_a = ux_q; mul_b = wy_q; end
      default: begin mul_a = uy_q; mul_b = wx_q; end
    endcase

    case (cmd_i.step[3:0])
      4'd0, 4'd1, 4'd2: sq_comp = 2'd0;
      4'd3, 4'd4, 4'd5: sq_comp = 2'd1;
      default:          sq_comp = 2'd2;
    endcase
    case (cmd_i.step[3:0])
      4'd0, 4'd3, 4'd6: sq_part = 2'd0;
      4'd1, 4'd4, 4'd7: sq_part = 2'd1;
      default:          sq_part = 2'd2;
    endcase
    sq_mag = mag_q[sq_comp];
    sq_a   = (sq_part == 2'd2) ? sq_mag[HALF_W-1:0] : sq_mag[SUM_W-1:HALF_W];
    sq_b   = (sq_part == 2'd0) ? sq_mag[SUM_W-1:HALF_W] : sq_mag[HALF_W-1:0];

    rt_rem   = {rem_q[REM_W-3:0], acc_q[SQ_W-1 -: 2]};
    rt_trial = REM_W'({root_q, 2'b01});
    rt_ge    = rt_rem >= rt_trial;

    dv_rem = {rem_q[REM_W-2:0], dsh_q[QUOT_W-1]};
    dv_div = REM_W'(root_q);
    dv_ge  = dv_rem >= dv_div;

    q_clamp  = (quo_q > ONE_Q14) ? ONE_Q14 : quo_q;
    q_signed = neg_q[cmd_i.sel] ? (~NORM_W'(q_clamp) + 1'b1) : NORM_W'(q_clamp);
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[vtx_addr] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
    if (pos_re) pos_rd_q <= pos_mem[corner_addr];
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    if (sum_re) sum_rd_q <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_CAPTURE: item_q <= item_i;
      CMD_POS_LAT: begin
        vx_q[cmd_i.sel] <= pos_rd_q[3*COORD_W-1:2*COORD_W];
        vy_q[cmd_i.sel] <= pos_rd_q[2*COORD_W-1:COORD_W];
        vz_q[cmd_i.sel] <= pos_rd_q[COORD_W-1:0];
      end
      CMD_DIFF: begin
        ux_q <= DIFF_W'(vx_q[1]) - DIFF_W'(vx_q[0]);
        uy_q <= DIFF_W'(vy_q[1]) - DIFF_W'(vy_q[0]);
        uz_q <= DIFF_W'(vz_q[1]) - DIFF_W'(vz_q[0]);
        wx_q <= DIFF_W'(vx_q[2]) - DIFF_W'(vx_q[0]);
        wy_q <= DIFF_W'(vy_q[2]) - DIFF_W'(vy_q[0]);
        wz_q <= DIFF_W'(vz_q[2]) - DIFF_W'(vz_q[0]);
      end
      CMD_MUL: begin
        prod_q <= mul_a * mul_b;
        pidx_q <= cmd_i.step[2:0];
        if (cmd_i.step != '0) begin
          case (pidx_q)
            3'd0:    nx_q <= CROSS_W'(prod_q);
            3'd1:    nx_q <= nx_q - CROSS_W'(prod_q);
            3'd2:    ny_q <= CROSS_W'(prod_q);
            3'd3:    ny_q <= ny_q - CROSS_W'(prod_q);
            3'd4:    nz_q <= CROSS_W'(prod_q);
            default: nz_q <= nz_q - CROSS_W'(prod_q);
          endcase
        end
      end
      CMD_NRM_LAT: begin
        mag_q[0] <= mag(sum_rd_q[3*SUM_W-1:2*SUM_W]);
        mag_q[1] <= mag(sum_rd_q[2*SUM_W-1:SUM_W]);
        mag_q[2] <= mag(sum_rd_q[SUM_W-1:0]);
        neg_q    <= {sum_rd_q[SUM_W-1], sum_rd_q[2*SUM_W-1], sum_rd_q[3*SUM_W-1]};
        acc_q    <= '0;
        root_q   <= '0;
        rem_q    <= '0;
        res_q.read_index  <= item_q.vertex_index;
        res_q.zero_length <= 1'b0;
      end
      CMD_SQ: begin
        sqp_q   <= sq_a * sq_b;
        spart_q <= sq_part;
        if (cmd_i.step != '0) begin
          case (spart_q)
            2'd0:    acc_q <= acc_q + (SQ_W'(sqp_q) << SQ_HI_SH);
            2'd1:    acc_q <= acc_q + (SQ_W'(sqp_q) << SQ_MID_SH);
            default: acc_q <= acc_q + SQ_W'(sqp_q);
          endcase
        end
      end
      CMD_SQRT: begin
        rem_q  <= rt_ge ? (rt_rem - rt_trial) : rt_rem;
        root_q <= {root_q[ROOT_W-2:0], rt_ge};
        acc_q  <= acc_q << 2;
      end
      CMD_DIV_INIT: begin
        rem_q <= REM_W'(mag_q[cmd_i.sel] >> 1);
        dsh_q <= {mag_q[cmd_i.sel][0], {FRAC_W{1'b0}}};
        quo_q <= '0;
      end
      CMD_DIV: begin
        rem_q <= dv_ge ? (dv_rem - dv_div) : dv_rem;
        dsh_q <= dsh_q << 1;
        quo_q <= {quo_q[QUOT_W-2:0], dv_ge};
      end
      CMD_DIV_END: begin
        case (cmd_i.sel)
          2'd0:    res_q.normal_x <= q_signed;
          2'd1:    res_q.normal_y <= q_signed;
          default: res_q.normal_z <= q_signed;
        endcase
      end
      CMD_ZERO: begin
        res_q.read_index  <= item_q.vertex_index;
        res_q.normal_x    <= '0;
        res_q.normal_y    <= '0;
        res_q.normal_z    <= '0;
        res_q.zero_length <= 1'b1;
      end
      CMD_PUSH: out_q <= res_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.cmd == CMD_PUSH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.op       = item_q.operation;
  assign status_o.vtx_ok   = in_range(item_q.vertex_index);
  assign status_o.tri_ok   = in_range(item_q.corner_a) && in_range(item_q.corner_b) &&
                             in_range(item_q.corner_c);
  assign status_o.sum_zero = (sum_rd_q == '0);
  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign result_o          = out_q;

endmodule

@@ rtl/vertex_normal_accumulate_core.sv @@
// Vertex normal accumulator, top level. Area-weighted smooth normals.
// Input channel in_if carries one command per transaction: operation 0 stores a
// position and clears its normal sum, 1 adds a triangle's face normal to its
// three corners, 2 reads one vertex normal in Q1.14.
// Only operation 2 produces a transaction on out_if.
// A triangle takes three position reads, six products through one 17x17
// multiplier and three sum read-modify-writes.
// A read takes a sum read, nine 24x24 partial squares, 49 square-root
// steps, then three 15-step quotient divisions, one bit per cycle each.
// One transaction is worked on at a time; in_if.ready is high while idle.
// A result sits in an output register; the next command is taken meanwhile,
// and a further read waits only if that register is still full.
// Reset clears the sequencer and output valid; memories are not cleared, so a
// vertex must be loaded before it is used in a triangle or read.
// Depends on vna_pkg, vna_if, vna_ctrl and vna_datapath.
module vertex_normal_accumulate_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  vna_in_if.sink    in_if,
  vna_out_if.source out_if
);
  import vna_pkg::*;

  item_t      item;
  result_t    res;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready, out_valid;

  assign item.operation    = in_if.operation;
  assign item.vertex_index = in_if.vertex_index;
  assign item.pos_x        = in_if.pos_x;
  assign item.pos_y        = in_if.pos_y;
  assign item.pos_z        = in_if.pos_z;
  assign item.corner_a     = in_if.corner_a;
  assign item.corner_b     = in_if.corner_b;
  assign item.corner_c     = in_if.corner_c;
  assign in_if.ready       = in_ready;

  assign out_if.valid       = out_valid;
  assign out_if.read_index  = res.read_index;
  assign out_if.normal_x    = res.normal_x;
  assign out_if.normal_y    = res.normal_y;
  assign out_if.normal_z    = res.normal_z;
  assign out_if.zero_length = res.zero_length;

  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  vna_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .out_ready_i (out_if.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .result_o    (res)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking bench for vertex_normal_accumulate_core: directed corner cases,
// a back-to-back triangle burst, then random mesh traffic checked against a model.
// Depends on vna_pkg, vna_if and vertex_normal_accumulate_core from the RTL.
`timescale 1ns / 1ps

module tb;
  import vna_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned BURST_TRIS  = 24;
  localparam int unsigned RAND_ITEMS  = 500;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  typedef struct {
    item_t it;
    bit    burst;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vna_in_if  in_bus ();
  vna_out_if out_bus ();

  vertex_normal_accumulate_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [COORD_W-1:0] pos_mem [VERTICES][3];
  logic signed [SUM_W-1:0]   sum_mem [VERTICES][3];
  result_t expected_normals [$];

  stim_t   pending [$];
  item_t   cur_item;
  int      gap_cnt;
  int      sent_cnt;
  int      got_cnt;
  int      wait_cnt;
  int      errors;
  int      cycles;
  bit      long_hold_done;

  // stimulus generation bookkeeping
  bit      gen_loaded [VERTICES];
  int      loaded_list [$];

  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] s,
                                                      longint n);
    longint t;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    lo = -hi - 1;
    t  = longint'(s) + n;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[SUM_W-1:0];
  endfunction

  function automatic logic signed [NORM_W-1:0] unit_comp(logic signed [SUM_W-1:0] s,
                                                         logic [63:0] root);
    logic [63:0] m;
    logic [63:0] q;
    m = s < 0 ? 64'(-longint'(s)) : 64'(longint'(s));
    q = (m << FRAC_W) / root;
    if (q > 64'd16384) q = 64'd16384;
    return s < 0 ? -NORM_W'(q) : NORM_W'(q);
  endfunction

  task automatic apply_item(input item_t it);
    longint   u [3];
    longint   w [3];
    longint   n [3];
    int       crn [3];
    logic [63:0]  m [3];
    logic [127:0] sq;
    logic [63:0]  root;
    logic [63:0]  c;
    result_t  r;
    case (it.operation)
      OP_LOAD: begin
        pos_mem[it.vertex_index][0] = it.pos_x;
        pos_mem[it.vertex_index][1] = it.pos_y;
        pos_mem[it.vertex_index][2] = it.pos_z;
        for (int k = 0; k < 3; k++) sum_mem[it.vertex_index][k] = '0;
      end
      OP_TRI: begin
        crn[0] = it.corner_a;
        crn[1] = it.corner_b;
        crn[2] = it.corner_c;
        for (int k = 0; k < 3; k++) begin
          u[k] = longint'(pos_mem[crn[1]][k]) - longint'(pos_mem[crn[0]][k]);
          w[k] = longint'(pos_mem[crn[2]][k]) - longint'(pos_mem[crn[0]][k]);
        end
        n[0] = u[1] * w[2] - u[2] * w[1];
        n[1] = u[2] * w[0] - u[0] * w[2];
        n[2] = u[0] * w[1] - u[1] * w[0];
        for (int v = 0; v < 3; v++)
          for (int k = 0; k < 3; k++)
            sum_mem[crn[v]][k] = sat_sum(sum_mem[crn[v]][k], n[k]);
      end
      OP_READ: begin
        r = '0;
        r.read_index  = it.vertex_index;
        r.zero_length = 1'b1;
        if (sum_mem[it.vertex_index][0] != 0 || sum_mem[it.vertex_index][1] != 0 ||
            sum_mem[it.vertex_index][2] != 0) begin
          sq = '0;
          for (int k = 0; k < 3; k++) begin
            m[k] = sum_mem[it.vertex_index][k] < 0 ?
                   64'(-longint'(sum_mem[it.vertex_index][k])) :
                   64'(longint'(sum_mem[it.vertex_index][k]));
            sq = sq + 128'(m[k]) * 128'(m[k]);
          end
          root = '0;
          for (int b = 48; b >= 0; b--) begin
            c = root | (64'd1 << b);
            if (128'(c) * 128'(c) <= sq) root = c;
          end
          r.normal_x    = unit_comp(sum_mem[it.vertex_index][0], root);
          r.normal_y    = unit_comp(sum_mem[it.vertex_index][1], root);
          r.normal_z    = unit_comp(sum_mem[it.vertex_index][2], root);
          r.zero_length = 1'b0;
        end
        expected_normals.insert(expected_normals.size(), r);
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic [1:0] op, input int idx, input int x, input int y,
                            input int z, input int a, input int b, input int c,
                            input bit burst);
    stim_t s;
    s.it.operation    = op;
    s.it.vertex_index = IDX_W'(idx);
    s.it.pos_x        = COORD_W'(x);
    s.it.pos_y        = COORD_W'(y);
    s.it.pos_z        = COORD_W'(z);
    s.it.corner_a     = IDX_W'(a);
    s.it.corner_b     = IDX_W'(b);
    s.it.corner_c     = IDX_W'(c);
    s.burst           = burst;
    if (op == OP_LOAD && !gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      loaded_list.insert(loaded_list.size(), idx);
    end
    pending.insert(pending.size(), s);
  endtask

  function automatic int any_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1023) - 512;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  task automatic build_stimulus();
    int pick;
    int vtx;
    // clamped direction: sum (-1,-1,0) has root 1
    queue_item(OP_LOAD, 10, 0, 0, 0, 1023, 0, 1023, 0);
    queue_item(OP_LOAD, 11, 1, -1, 0, 0, 1023, 0, 0);
    queue_item(OP_LOAD, 12, 0, 0, 1, 1023, 1023, 1023, 0);
    queue_item(OP_TRI, 1023, -1, -1, -1, 10, 11, 12, 0);
    queue_item(OP_READ, 10, -32768, 32767, -1, 0, 0, 0, 0);
    queue_item(OP_READ, 11, 0, 0, 0, 1023, 1023, 1023, 0);
    queue_item(OP_READ, 12, 0, 0, 0, 0, 0, 0, 0);
    // repeated corners add nothing
    queue_item(OP_TRI, 0, 0, 0, 0, 10, 10, 11, 0);
    queue_item(OP_READ, 10, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_SPARE, 1023, -1, -1, -1, 1023, 1023, 1023, 0);
    queue_item(OP_SPARE, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_LOAD, 1023, -32768, 32767, -1, 0, 0, 0, 0);
    queue_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_LOAD, 0, 32767, -32768, 0, 0, 0, 0, 0);
    queue_item(OP_TRI, 0, 0, 0, 0, 1023, 0, 12, 0);
    queue_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0);
    // reload clears the sum
    queue_item(OP_LOAD, 10, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_READ, 10, 0, 0, 0, 0, 0, 0, 0);
    // largest face normal, repeated back to back
    queue_item(OP_LOAD, 1000, 32767, 32767, -32768, 0, 0, 0, 0);
    queue_item(OP_LOAD, 1001, -32768, -32768, -32768, 0, 0, 0, 0);
    queue_item(OP_LOAD, 1002, -32768, 32767, 32767, 0, 0, 0, 0);
    queue_item(OP_READ, 1000, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < BURST_TRIS; i++)
      queue_item(OP_TRI, 0, 0, 0, 0, 1000, 1001, 1002, 1);
    queue_item(OP_READ, 1000, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_READ, 1001, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_READ, 1002, 0, 0, 0, 0, 0, 0, 0);
    queue_item(OP_TRI, 0, 0, 0, 0, 1002, 1001, 1000, 0);
    queue_item(OP_READ, 1002, 0, 0, 0, 0, 0, 0, 0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20 || loaded_list.size() < 40) begin
        vtx = (loaded_list.size() < 40 || $urandom_range(0, 2) == 0) ?
              $urandom_range(0, VERTICES - 1) : any_loaded();
        queue_item(OP_LOAD, vtx, rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 0);
      end else if (pick < 60) begin
        vtx = any_loaded();
        queue_item(OP_TRI, $urandom_range(0, 1023), rand_coord(), rand_coord(),
                   rand_coord(), vtx,
                   $urandom_range(0, 9) == 0 ? vtx : any_loaded(), any_loaded(), 0);
      end else if (pick < 95) begin
        queue_item(OP_READ, any_loaded(), rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 0);
      end else begin
        queue_item(OP_SPARE, $urandom_range(0, 1023), rand_coord(), rand_coord(),
                   rand_coord(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), 0);
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    stim_t nxt;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        apply_item(cur_item);
        sent_cnt++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_cnt != 0) begin
          in_bus.valid <= 1'b0;
          gap_cnt <= gap_cnt - 1;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          cur_item               <= nxt.it;
          in_bus.operation       <= nxt.it.operation;
          in_bus.vertex_index    <= nxt.it.vertex_index;
          in_bus.pos_x           <= nxt.it.pos_x;
          in_bus.pos_y           <= nxt.it.pos_y;
          in_bus.pos_z           <= nxt.it.pos_z;
          in_bus.corner_a        <= nxt.it.corner_a;
          in_bus.corner_b        <= nxt.it.corner_b;
          in_bus.corner_c        <= nxt.it.corner_c;
          in_bus.valid           <= 1'b1;
          gap_cnt <= (nxt.burst || (sent_cnt / 40) % 3 == 0) ? 0 : $urandom_range(0, 14);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    result_t exp_r;
    int w;
    if (rst_ni) begin
      w = wait_cnt;
      if (out_bus.valid && out_bus.ready) begin
        got_cnt++;
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected transaction, index %0d", $time, out_bus.read_index);
          errors++;
        end else begin
          exp_r = expected_normals.pop_front();
          if (out_bus.read_index !== exp_r.read_index) begin
            $display("%0t: read_index exp %0d got %0d", $time, exp_r.read_index,
                     out_bus.read_index);
            errors++;
          end
          if (out_bus.normal_x !== exp_r.normal_x) begin
            $display("%0t: normal_x exp %0d got %0d", $time, exp_r.normal_x,
                     out_bus.normal_x);
            errors++;
          end
          if (out_bus.normal_y !== exp_r.normal_y) begin
            $display("%0t: normal_y exp %0d got %0d", $time, exp_r.normal_y,
                     out_bus.normal_y);
            errors++;
          end
          if (out_bus.normal_z !== exp_r.normal_z) begin
            $display("%0t: normal_z exp %0d got %0d", $time, exp_r.normal_z,
                     out_bus.normal_z);
            errors++;
          end
          if (out_bus.zero_length !== exp_r.zero_length) begin
            $display("%0t: zero_length exp %0b got %0b", $time, exp_r.zero_length,
                     out_bus.zero_length);
            errors++;
          end
        end
        w = (got_cnt / 25) % 3 == 1 ? 0 : $urandom_range(0, 14);
        // long back-pressure so the output register fills and input stalls
        if (!long_hold_done && got_cnt == 30) begin
          w = 1500;
          long_hold_done = 1'b1;
        end
      end
      if (w != 0) begin
        out_bus.ready <= 1'b0;
        wait_cnt <= w - 1;
      end else begin
        out_bus.ready <= 1'b1;
        wait_cnt <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.operation    = OP_LOAD;
    in_bus.vertex_index = '0;
    in_bus.pos_x        = '0;
    in_bus.pos_y        = '0;
    in_bus.pos_z        = '0;
    in_bus.corner_a     = '0;
    in_bus.corner_b     = '0;
    in_bus.corner_c     = '0;
    out_bus.ready       = 1'b0;
    cur_item            = '0;
    gap_cnt             = 0;
    sent_cnt            = 0;
    got_cnt             = 0;
    wait_cnt            = 0;
    errors              = 0;
    cycles              = 0;
    long_hold_done      = 1'b0;
    build_stimulus();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (pending.size() != 0 || in_bus.valid);
    do @(posedge clk_i); while (expected_normals.size() != 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/vna_pkg.sv
rtl/vna_if.sv
rtl/vna_ctrl.sv
rtl/vna_datapath.sv
rtl/vertex_normal_accumulate_core.sv
verif/tb.sv
